// ===== src/first_negative_in_window_defines.svh =====
// Assertion macros for the first_negative_in_window block.
// Used by the port checker; needs nothing else.
`ifndef FIRST_NEGATIVE_IN_WINDOW_DEFINES_SVH
`define FIRST_NEGATIVE_IN_WINDOW_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define FNW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fnw check failed");

// Next-cycle implication, masked while reset is asserted
`define FNW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fnw check failed");

`endif

// ===== src/fnw_pkg.sv =====
// Shared constants and types for the first-negative-in-window block.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package fnw_pkg;

  // Default sizes
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 32;

  // Width of the window length configuration input
  localparam int CFG_BITS = 9;

  // Per-beat control broadcast to every cell
  typedef struct packed {
    logic advance;  // a sample beat is taken, shift the row
    logic clear;    // sequence restarts, drop every held negative
  } fnw_ctrl_t;

endpackage

`default_nettype wire

// ===== src/fnw_cell.sv =====
// One cell of the window row: holds the oldest negative seen over a window
// that grows by one each step from its start cell. Depends on fnw_pkg.
`default_nettype none

module fnw_cell #(
  parameter int SAMPLE_BITS = fnw_pkg::SAMPLE_BITS_DEF,
  parameter int IW          = 8,
  parameter int IDX         = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fnw_pkg::fnw_ctrl_t     ctrl,
  input  wire logic [IW-1:0]          start_idx,
  input  wire logic [SAMPLE_BITS-1:0] new_sample,
  input  wire logic                   left_found,
  input  wire logic [SAMPLE_BITS-1:0] left_value,
  output logic                        found_r,
  output logic [SAMPLE_BITS-1:0]      value_r,
  output logic                        cand_found,
  output logic [SAMPLE_BITS-1:0]      cand_value
);

  logic                   is_start;
  logic                   new_neg;
  logic                   found_nxt;
  logic [SAMPLE_BITS-1:0] value_nxt;

  assign is_start = (start_idx == IW'(IDX));
  assign new_neg  = new_sample[SAMPLE_BITS-1];

  // Older negative from the left wins, except in the start cell; otherwise the incoming sample
  always_comb begin
    if (!is_start && left_found) begin
      cand_found = 1'b1;
      cand_value = left_value;
    end else begin
      cand_found = new_neg;
      cand_value = new_sample;
    end
  end

  always_comb begin
    found_nxt = found_r;
    value_nxt = value_r;
    if (ctrl.clear) begin
      found_nxt = 1'b0;
    end else if (ctrl.advance) begin
      found_nxt = cand_found;
      value_nxt = cand_value;
    end
  end

  // Flag needs reset; value only matters while the flag is set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// ===== src/first_negative_in_window.sv =====
// first_negative_in_window: a row of WINDOW_MAX cells finds the oldest
// negative sample in a sliding window of K samples.
//
// Input channel: in_valid / in_stall carrying in_sample (two's complement)
// and in_last. A beat is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall carrying out_first_negative, the
// oldest negative sample of the window that ends with the sample just
// taken, or 0 if that window holds none.
// Configuration: cfg_valid / cfg_ready carrying cfg_window_size (K); 0
// counts as 1 and values above WINDOW_MAX saturate. A write restarts the
// sequence. cfg_ready is always high; write only while the block is idle.
// Throughput: one sample per clock while in_stall is low. The result is on
// the output register in the cycle after its sample is taken. The first
// K-1 samples of a sequence give no result; in_last ends the sequence.
// Reset (synchronous, rst_n low) empties the window and sets K to 1.
// While the receiver stalls a waiting result, in_stall is raised, so at
// most one result is held and none is lost.
`default_nettype none

module first_negative_in_window #(
  parameter int WINDOW_MAX  = fnw_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = fnw_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [SAMPLE_BITS-1:0]        in_sample,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [SAMPLE_BITS-1:0]             out_first_negative,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fnw_pkg::CFG_BITS-1:0]  cfg_window_size
);

  localparam int KW   = $clog2(WINDOW_MAX + 1);
  localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMPW = (KW > fnw_pkg::CFG_BITS) ? KW : fnw_pkg::CFG_BITS;

  localparam logic [CMPW-1:0] WMAX_C = CMPW'(WINDOW_MAX);
  localparam logic [KW-1:0]   WMAX_K = KW'(WINDOW_MAX);

  logic                   in_acc;
  logic                   cfg_we;
  fnw_pkg::fnw_ctrl_t     ctrl;

  logic [KW-1:0]          k_r, k_nxt;
  logic [IW-1:0]          start_r, start_nxt;
  logic [KW-1:0]          fill_r, fill_nxt;
  logic [KW-1:0]          fill_inc;
  logic                   produce;

  logic [CMPW-1:0]        ws_ext;
  logic [KW-1:0]          k_cfg;

  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  logic [WINDOW_MAX-1:0]  found_row;
  logic [SAMPLE_BITS-1:0] value_row [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  cand_found_row;
  logic [SAMPLE_BITS-1:0] cand_value_row [WINDOW_MAX];

  // Handshakes
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign ctrl.advance = in_acc;
  assign ctrl.clear   = cfg_we || (in_acc && in_last);

  // Effective window length: 0 -> 1, above the row length -> row length
  assign ws_ext = CMPW'(cfg_window_size);
  always_comb begin
    if (ws_ext == '0) begin
      k_cfg = KW'(1);
    end else if (ws_ext > WMAX_C) begin
      k_cfg = WMAX_K;
    end else begin
      k_cfg = KW'(ws_ext);
    end
  end

  // Window length and start cell of the row
  always_comb begin
    k_nxt     = k_r;
    start_nxt = start_r;
    if (cfg_we) begin
      k_nxt     = k_cfg;
      start_nxt = IW'(WMAX_K - k_cfg);
    end
  end

  // Fill count, saturating at K
  assign fill_inc = (fill_r < k_r) ? fill_r + KW'(1) : fill_r;
  assign produce  = (fill_inc >= k_r);

  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.clear) begin
      fill_nxt = '0;
    end else if (in_acc) begin
      fill_nxt = fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= KW'(1);
      start_r <= IW'(WMAX_K - KW'(1));
      fill_r  <= '0;
    end else begin
      k_r     <= k_nxt;
      start_r <= start_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Row of cells; cell 0 has no left neighbour
  for (genvar c = 0; c < WINDOW_MAX; c++) begin : g_cell
    logic                   left_found;
    logic [SAMPLE_BITS-1:0] left_value;
    if (c == 0) begin : g_first
      assign left_found = 1'b0;
      assign left_value = '0;
    end else begin : g_rest
      assign left_found = found_row[c-1];
      assign left_value = value_row[c-1];
    end

    fnw_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IW          (IW),
      .IDX         (c)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .start_idx  (start_r),
      .new_sample (in_sample),
      .left_found (left_found),
      .left_value (left_value),
      .found_r    (found_row[c]),
      .value_r    (value_row[c]),
      .cand_found (cand_found_row[c]),
      .cand_value (cand_value_row[c])
    );
  end

  // Output register, loaded from the last cell's candidate
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc && produce) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = cand_found_row[WINDOW_MAX-1] ? cand_value_row[WINDOW_MAX-1] : '0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_first_negative = out_data_r;

endmodule

`default_nettype wire

// ===== src/fnw_checker.sv =====
// Port-level checks for first_negative_in_window, bound to the top level.
// Depends on fnw_pkg and first_negative_in_window_defines.svh.
`default_nettype none
`include "first_negative_in_window_defines.svh"

module fnw_checker #(
  parameter int SAMPLE_BITS = fnw_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [SAMPLE_BITS-1:0] out_first_negative
);

  // A held result beat keeps its data
  `FNW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_first_negative))

  // Input is only held back by a stalled result
  `FNW_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // A result is either zero or a negative sample
  `FNW_ASSERT_IMP(a_res_sign, clk, rst_n, out_valid, out_first_negative[SAMPLE_BITS-1] || (out_first_negative == '0))

  // A fresh result follows a taken sample beat
  `FNW_ASSERT_IMP(a_res_cause, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall))

endmodule

bind first_negative_in_window fnw_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fnw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_first_negative (out_first_negative)
);

`default_nettype wire
